[sv/ccfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccfs_pkg
// Shared types, codes and helper functions of the calendar clock field setter.
// ----------------------------------------------------------------------------
package ccfs_pkg;

  // Event codes carried on the opcode field.
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_SET  = 2'd1,
    OP_INC  = 2'd2,
    OP_DEC  = 2'd3
  } opcode_e;

  // Setting modes; the set key steps through them and wraps back to none.
  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_HOUR   = 3'd1,
    MODE_MINUTE = 3'd2,
    MODE_SECOND = 3'd3,
    MODE_DAY    = 3'd4,
    MODE_MONTH  = 3'd5,
    MODE_YEAR   = 3'd6,
    MODE_IDLE   = 3'd7
  } mode_e;

  // Wrap moduli of the fields.
  localparam logic [7:0] HOUR_MOD  = 8'd24;
  localparam logic [7:0] MIN_MOD   = 8'd60;
  localparam logic [7:0] YEAR_MOD  = 8'd100;
  localparam logic [7:0] MONTH_MOD = 8'd12;

  // Time and date fields plus the setting mode.
  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } clock_state_t;

  // Reduce a value below three times the modulus into range by subtracting
  // either twice the modulus, the modulus once, or nothing.
  function automatic logic [7:0] wrap2(input logic [7:0] x, input logic [7:0] m);
    logic [7:0] m2;
    logic [7:0] r;
    m2 = {m[6:0], 1'b0};
    if (x >= m2) begin
      r = x - m2;
    end else if (x >= m) begin
      r = x - m;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Length of a month; months outside 1 to 12 are given 31 days.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

[sv/ccfs_field_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccfs_field_calc
// Next clock state for one event: load, mode step, or wrapped increase and
// decrease of the selected field. Pure combinational logic.
// ----------------------------------------------------------------------------
module ccfs_field_calc (
  input  ccfs_pkg::clock_state_t cur_i,
  input  logic [1:0]             opcode_i,
  input  logic [4:0]             load_hour_i,
  input  logic [5:0]             load_minute_i,
  input  logic [5:0]             load_second_i,
  input  logic [4:0]             load_day_i,
  input  logic [3:0]             load_month_i,
  input  logic [6:0]             load_year_i,
  output ccfs_pkg::clock_state_t nxt_o,
  output logic [5:0]             mask_o,
  output logic                   write_back_o
);

  logic       leap;
  logic [4:0] len;
  logic [7:0] hour_up, hour_dn, min_up, min_dn, sec_up, sec_dn;
  logic [7:0] year_up, year_dn, month_up, month_dn, day_up, day_dn;

  // Leap years are those with the two-digit year a multiple of four.
  assign leap = (cur_i.year[1:0] == 2'b00);
  assign len  = ccfs_pkg::month_days(cur_i.month, leap);

  // Wrapped neighbors of every field.
  always_comb begin
    hour_up  = ccfs_pkg::wrap2({3'b0, cur_i.hour} + 8'd1, ccfs_pkg::HOUR_MOD);
    hour_dn  = ccfs_pkg::wrap2({3'b0, cur_i.hour} + 8'd23, ccfs_pkg::HOUR_MOD);
    min_up   = ccfs_pkg::wrap2({2'b0, cur_i.minute} + 8'd1, ccfs_pkg::MIN_MOD);
    min_dn   = ccfs_pkg::wrap2({2'b0, cur_i.minute} + 8'd59, ccfs_pkg::MIN_MOD);
    sec_up   = ccfs_pkg::wrap2({2'b0, cur_i.second} + 8'd1, ccfs_pkg::MIN_MOD);
    sec_dn   = ccfs_pkg::wrap2({2'b0, cur_i.second} + 8'd59, ccfs_pkg::MIN_MOD);
    year_up  = ccfs_pkg::wrap2({1'b0, cur_i.year} + 8'd1, ccfs_pkg::YEAR_MOD);
    year_dn  = ccfs_pkg::wrap2({1'b0, cur_i.year} + 8'd99, ccfs_pkg::YEAR_MOD);
    month_up = ccfs_pkg::wrap2({4'b0, cur_i.month}, ccfs_pkg::MONTH_MOD) + 8'd1;
    month_dn = ccfs_pkg::wrap2({4'b0, cur_i.month} + 8'd11, ccfs_pkg::MONTH_MOD);
    if (month_dn == 8'd0) begin
      month_dn = ccfs_pkg::MONTH_MOD;
    end
    day_up   = ccfs_pkg::wrap2({3'b0, cur_i.day}, {3'b0, len}) + 8'd1;
    day_dn   = ccfs_pkg::wrap2({3'b0, cur_i.day} + {3'b0, len} - 8'd1, {3'b0, len});
    if (day_dn == 8'd0) begin
      day_dn = {3'b0, len};
    end
  end

  // Select the new state from the event and the current mode.
  always_comb begin
    nxt_o        = cur_i;
    write_back_o = 1'b0;
    case (opcode_i)
      ccfs_pkg::OP_LOAD: begin
        nxt_o.hour   = load_hour_i;
        nxt_o.minute = load_minute_i;
        nxt_o.second = load_second_i;
        nxt_o.day    = load_day_i;
        nxt_o.month  = load_month_i;
        nxt_o.year   = load_year_i;
      end
      ccfs_pkg::OP_SET: begin
        nxt_o.mode = cur_i.mode + 3'd1;
      end
      ccfs_pkg::OP_INC: begin
        write_back_o = 1'b1;
        case (cur_i.mode)
          ccfs_pkg::MODE_HOUR:   nxt_o.hour   = hour_up[4:0];
          ccfs_pkg::MODE_MINUTE: nxt_o.minute = min_up[5:0];
          ccfs_pkg::MODE_SECOND: nxt_o.second = sec_up[5:0];
          ccfs_pkg::MODE_DAY:    nxt_o.day    = day_up[4:0];
          ccfs_pkg::MODE_MONTH:  nxt_o.month  = month_up[3:0];
          ccfs_pkg::MODE_YEAR:   nxt_o.year   = year_up[6:0];
          default: ;
        endcase
      end
      default: begin
        write_back_o = 1'b1;
        case (cur_i.mode)
          ccfs_pkg::MODE_HOUR:   nxt_o.hour   = hour_dn[4:0];
          ccfs_pkg::MODE_MINUTE: nxt_o.minute = min_dn[5:0];
          ccfs_pkg::MODE_SECOND: nxt_o.second = sec_dn[5:0];
          ccfs_pkg::MODE_DAY:    nxt_o.day    = day_dn[4:0];
          ccfs_pkg::MODE_MONTH:  nxt_o.month  = month_dn[3:0];
          ccfs_pkg::MODE_YEAR:   nxt_o.year   = year_dn[6:0];
          default: ;
        endcase
      end
    endcase
  end

  // Highlight follows the mode after the event; none in modes none and idle.
  always_comb begin
    case (nxt_o.mode)
      ccfs_pkg::MODE_HOUR:   mask_o = 6'b000001;
      ccfs_pkg::MODE_MINUTE: mask_o = 6'b000010;
      ccfs_pkg::MODE_SECOND: mask_o = 6'b000100;
      ccfs_pkg::MODE_DAY:    mask_o = 6'b001000;
      ccfs_pkg::MODE_MONTH:  mask_o = 6'b010000;
      ccfs_pkg::MODE_YEAR:   mask_o = 6'b100000;
      default:               mask_o = 6'b000000;
    endcase
  end

endmodule
`default_nettype wire

[sv/calendar_clock_field_setter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_field_setter
// Key-driven setting of a decimal calendar clock with mode and highlight.
// ----------------------------------------------------------------------------
// Each event transfer (load, set key, increase, decrease) produces exactly one
// result transfer carrying the mode, all six time and date fields after the
// event, a one-hot highlight of the selected field and a write-back flag. An
// event is held in the input register until the result register is free or
// draining; then the field logic updates the clock registers, which also form
// the result register that presents the result. One event is taken per cycle
// as long as the result side does not stall; the input stalls only while a
// held event waits for a full, stalled result register.
// ----------------------------------------------------------------------------
module calendar_clock_field_setter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [4:0] load_hour_i,
  input  logic [5:0] load_minute_i,
  input  logic [5:0] load_second_i,
  input  logic [4:0] load_day_i,
  input  logic [3:0] load_month_i,
  input  logic [6:0] load_year_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] set_mode_o,
  output logic [4:0] hour_now_o,
  output logic [5:0] minute_now_o,
  output logic [5:0] second_now_o,
  output logic [4:0] day_now_o,
  output logic [3:0] month_now_o,
  output logic [6:0] year_now_o,
  output logic [5:0] highlight_mask_o,
  output logic       write_back_o
);

  logic                   in_vld_q;
  logic [1:0]             op_q;
  logic [4:0]             ld_hour_q;
  logic [5:0]             ld_minute_q;
  logic [5:0]             ld_second_q;
  logic [4:0]             ld_day_q;
  logic [3:0]             ld_month_q;
  logic [6:0]             ld_year_q;
  logic                   out_vld_q;
  ccfs_pkg::clock_state_t state_q, state_d;
  logic [5:0]             mask_q, mask_d;
  logic                   wb_q, wb_d;
  logic                   advance;
  logic                   in_take;

  // The held event moves on when the result register is free or draining.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q        <= opcode_i;
      ld_hour_q   <= load_hour_i;
      ld_minute_q <= load_minute_i;
      ld_second_q <= load_second_i;
      ld_day_q    <= load_day_i;
      ld_month_q  <= load_month_i;
      ld_year_q   <= load_year_i;
    end
  end

  // Field update logic.
  ccfs_field_calc u_calc (
    .cur_i         (state_q),
    .opcode_i      (op_q),
    .load_hour_i   (ld_hour_q),
    .load_minute_i (ld_minute_q),
    .load_second_i (ld_second_q),
    .load_day_i    (ld_day_q),
    .load_month_i  (ld_month_q),
    .load_year_i   (ld_year_q),
    .nxt_o         (state_d),
    .mask_o        (mask_d),
    .write_back_o  (wb_d)
  );

  // Clock state and result register; the state only moves with a result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q      <= 1'b0;
      state_q.mode   <= ccfs_pkg::MODE_NONE;
      state_q.hour   <= 5'd10;
      state_q.minute <= 6'd27;
      state_q.second <= 6'd0;
      state_q.day    <= 5'd5;
      state_q.month  <= 4'd5;
      state_q.year   <= 7'd9;
      mask_q         <= 6'd0;
      wb_q           <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
      state_q   <= state_d;
      mask_q    <= mask_d;
      wb_q      <= wb_d;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign set_mode_o       = state_q.mode;
  assign hour_now_o       = state_q.hour;
  assign minute_now_o     = state_q.minute;
  assign second_now_o     = state_q.second;
  assign day_now_o        = state_q.day;
  assign month_now_o      = state_q.month;
  assign year_now_o       = state_q.year;
  assign highlight_mask_o = mask_q;
  assign write_back_o     = wb_q;

`ifndef ASSERT_OFF
  // At most one field is highlighted.
  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(mask_q))
    else $error("highlight mask has more than one bit set");

  // Highlight is empty exactly in modes none and idle.
  a_mask_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((mask_q == 6'd0) ==
      (state_q.mode == ccfs_pkg::MODE_NONE || state_q.mode == ccfs_pkg::MODE_IDLE)))
    else $error("highlight mask does not match mode");

  // A set key steps the mode by one.
  a_mode_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == ccfs_pkg::OP_SET) |=> (state_q.mode == $past(state_q.mode) + 3'd1))
    else $error("set key did not step the mode");

  // An hour increase always lands in range.
  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == ccfs_pkg::OP_INC && state_q.mode == ccfs_pkg::MODE_HOUR)
      |=> (state_q.hour < 5'd24))
    else $error("hour increase left the range");

  // The input stalls only while an event is held.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a held event");
`endif

endmodule
`default_nettype wire

[tb/sv/ccfs_setting_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccfs_setting_checker
// Watches both channels of the calendar clock field setter, keeps its own copy
// of the clock and setting mode, predicts the result of every event transfer
// and compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ccfs_setting_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] opcode_i,
  input  logic [4:0] load_hour_i,
  input  logic [5:0] load_minute_i,
  input  logic [5:0] load_second_i,
  input  logic [4:0] load_day_i,
  input  logic [3:0] load_month_i,
  input  logic [6:0] load_year_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] set_mode_i,
  input  logic [4:0] hour_now_i,
  input  logic [5:0] minute_now_i,
  input  logic [5:0] second_now_i,
  input  logic [4:0] day_now_i,
  input  logic [3:0] month_now_i,
  input  logic [6:0] year_now_i,
  input  logic [5:0] highlight_mask_i,
  input  logic       write_back_i,
  output int         mismatches_o,
  output int         pending_o
);

  // What the block shows after one event.
  typedef struct packed {
    ccfs_pkg::clock_state_t fields;
    logic [5:0]             highlight;
    logic                   write_back;
  } clock_view_t;

  // Clock contents right after reset.
  localparam ccfs_pkg::clock_state_t POWER_ON = '{
    mode: ccfs_pkg::MODE_NONE, hour: 5'd10, minute: 6'd27, second: 6'd0,
    day: 5'd5, month: 4'd5, year: 7'd9
  };

  ccfs_pkg::clock_state_t clock_q;
  clock_view_t            awaited_q[$];
  int                     mismatch_count = 0;
  int                     pending_count = 0;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  // Days in the current month; a month outside 1 to 12 counts as 31 days.
  function automatic int month_length(input logic [3:0] month, input logic [6:0] year);
    if (month == 4'd0 || month > 4'd12) return 31;
    if (month == 4'd2) return (year[1:0] == 2'b00) ? 29 : 28;
    return (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) ? 30 : 31;
  endfunction

  // Applies one event to the clock and works out what the block then shows.
  function automatic clock_view_t next_view(input ccfs_pkg::clock_state_t cur,
                                            input ccfs_pkg::opcode_e op,
                                            input ccfs_pkg::clock_state_t loaded);
    clock_view_t r;
    logic        step_up;
    int          len;
    int          v;
    r.fields     = cur;
    r.highlight  = '0;
    r.write_back = 1'b0;
    step_up      = (op == ccfs_pkg::OP_INC);
    case (op)
      ccfs_pkg::OP_LOAD: begin
        // The mode survives a load; the fields take the raw values.
        r.fields.hour   = loaded.hour;
        r.fields.minute = loaded.minute;
        r.fields.second = loaded.second;
        r.fields.day    = loaded.day;
        r.fields.month  = loaded.month;
        r.fields.year   = loaded.year;
      end
      ccfs_pkg::OP_SET: begin
        r.fields.mode = cur.mode + 3'd1;
      end
      default: begin
        r.write_back = 1'b1;
        case (ccfs_pkg::mode_e'(cur.mode))
          ccfs_pkg::MODE_HOUR:
            r.fields.hour = step_up ? 5'((cur.hour + 1) % 24) : 5'((cur.hour + 23) % 24);
          ccfs_pkg::MODE_MINUTE:
            r.fields.minute = step_up ? 6'((cur.minute + 1) % 60) : 6'((cur.minute + 59) % 60);
          ccfs_pkg::MODE_SECOND:
            r.fields.second = step_up ? 6'((cur.second + 1) % 60) : 6'((cur.second + 59) % 60);
          ccfs_pkg::MODE_DAY: begin
            len = month_length(cur.month, cur.year);
            if (step_up) begin
              r.fields.day = 5'(cur.day % len + 1);
            end else begin
              v = (cur.day + len - 1) % len;
              r.fields.day = (v == 0) ? 5'(len) : 5'(v);
            end
          end
          ccfs_pkg::MODE_MONTH: begin
            if (step_up) begin
              r.fields.month = 4'(cur.month % 12 + 1);
            end else begin
              v = (cur.month + 11) % 12;
              r.fields.month = (v == 0) ? 4'd12 : 4'(v);
            end
          end
          ccfs_pkg::MODE_YEAR:
            r.fields.year = step_up ? 7'((cur.year + 1) % 100) : 7'((cur.year + 99) % 100);
          default: ;
        endcase
      end
    endcase
    // Only the six field-setting modes light a field.
    if (r.fields.mode >= ccfs_pkg::MODE_HOUR && r.fields.mode <= ccfs_pkg::MODE_YEAR) begin
      r.highlight = 6'd1 << (r.fields.mode - 3'd1);
    end
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("%0t ccfs_setting_checker: %s", $time, msg);
    mismatch_count = mismatch_count + 1;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Predict on every event transfer, compare on every result transfer.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    clock_view_t            want;
    ccfs_pkg::clock_state_t loaded;
    if (!rst_ni) begin
      clock_q = POWER_ON;
      awaited_q.delete();
      pending_count <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        loaded.mode   = clock_q.mode;
        loaded.hour   = load_hour_i;
        loaded.minute = load_minute_i;
        loaded.second = load_second_i;
        loaded.day    = load_day_i;
        loaded.month  = load_month_i;
        loaded.year   = load_year_i;
        want = next_view(clock_q, ccfs_pkg::opcode_e'(opcode_i), loaded);
        clock_q = want.fields;
        awaited_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result transfer with no event awaiting it");
        end else begin
          want = awaited_q.pop_front();
          check_field("set_mode", set_mode_i, want.fields.mode);
          check_field("hour_now", hour_now_i, want.fields.hour);
          check_field("minute_now", minute_now_i, want.fields.minute);
          check_field("second_now", second_now_i, want.fields.second);
          check_field("day_now", day_now_i, want.fields.day);
          check_field("month_now", month_now_i, want.fields.month);
          check_field("year_now", year_now_i, want.fields.year);
          check_field("highlight_mask", highlight_mask_i, want.highlight);
          check_field("write_back", write_back_i, want.write_back);
        end
      end
      pending_count <= awaited_q.size();
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_calendar_clock_field_setter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_calendar_clock_field_setter
// Drives key events and clock loads into the calendar clock field setter.
// A directed run walks every mode, every key and the wrap corners (out of
// range loads, leap February, month and year wraps); a long random run with
// bursty stalls on both channels follows. The checker beside the block does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_calendar_clock_field_setter;

  localparam int RANDOM_EVENTS = 2000;
  localparam int CALM_TAIL     = 250;
  localparam int CYCLE_LIMIT   = 400000;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                ev_valid = 1'b0;
  logic                ev_stall;
  ccfs_pkg::opcode_e   ev_op = ccfs_pkg::OP_LOAD;
  logic [4:0]          ld_hour = '0;
  logic [5:0]          ld_minute = '0;
  logic [5:0]          ld_second = '0;
  logic [4:0]          ld_day = '0;
  logic [3:0]          ld_month = '0;
  logic [6:0]          ld_year = '0;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [2:0]          set_mode;
  logic [4:0]          hour_now;
  logic [5:0]          minute_now;
  logic [5:0]          second_now;
  logic [4:0]          day_now;
  logic [3:0]          month_now;
  logic [6:0]          year_now;
  logic [5:0]          highlight_mask;
  logic                write_back;
  int                  mismatches;
  int                  pending;
  logic                calm = 1'b0;
  logic                stall_phase_on = 1'b1;
  int                  stall_left = 0;
  int                  cycles = 0;

  calendar_clock_field_setter uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (ev_valid),
    .in_stall_o       (ev_stall),
    .opcode_i         (ev_op),
    .load_hour_i      (ld_hour),
    .load_minute_i    (ld_minute),
    .load_second_i    (ld_second),
    .load_day_i       (ld_day),
    .load_month_i     (ld_month),
    .load_year_i      (ld_year),
    .out_valid_o      (res_valid),
    .out_stall_i      (res_stall),
    .set_mode_o       (set_mode),
    .hour_now_o       (hour_now),
    .minute_now_o     (minute_now),
    .second_now_o     (second_now),
    .day_now_o        (day_now),
    .month_now_o      (month_now),
    .year_now_o       (year_now),
    .highlight_mask_o (highlight_mask),
    .write_back_o     (write_back)
  );

  ccfs_setting_checker checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (ev_valid),
    .in_stall_i       (ev_stall),
    .opcode_i         (ev_op),
    .load_hour_i      (ld_hour),
    .load_minute_i    (ld_minute),
    .load_second_i    (ld_second),
    .load_day_i       (ld_day),
    .load_month_i     (ld_month),
    .load_year_i      (ld_year),
    .out_valid_i      (res_valid),
    .out_stall_i      (res_stall),
    .set_mode_i       (set_mode),
    .hour_now_i       (hour_now),
    .minute_now_i     (minute_now),
    .second_now_i     (second_now),
    .day_now_i        (day_now),
    .month_now_i      (month_now),
    .year_now_i       (year_now),
    .highlight_mask_i (highlight_mask),
    .write_back_i     (write_back),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_calendar_clock_field_setter: done, errors");
      $finish;
    end
  end

  // Result side stalls in bursts; some stretches have no stalls at all.
  always @(posedge clk) begin
    if (cycles % 256 == 0) begin
      stall_phase_on <= ($urandom_range(0, 3) != 0);
    end
    if (stall_left != 0) begin
      res_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && stall_phase_on && $urandom_range(0, 5) == 0) begin
      res_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 16);
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Mostly plausible clock readings, now and then raw values at full width.
  function automatic ccfs_pkg::clock_state_t random_load();
    ccfs_pkg::clock_state_t ld;
    ld.mode = ccfs_pkg::MODE_NONE;
    if ($urandom_range(0, 4) == 0) begin
      ld.hour   = 5'($urandom);
      ld.minute = 6'($urandom);
      ld.second = 6'($urandom);
      ld.day    = 5'($urandom);
      ld.month  = 4'($urandom);
      ld.year   = 7'($urandom);
    end else begin
      ld.hour   = 5'($urandom_range(0, 23));
      ld.minute = 6'($urandom_range(0, 59));
      ld.second = 6'($urandom_range(0, 59));
      ld.day    = 5'($urandom_range(1, 31));
      ld.month  = 4'($urandom_range(1, 12));
      ld.year   = 7'($urandom_range(0, 99));
    end
    return ld;
  endfunction

  // Presents one event and holds it until the transfer happens.
  task automatic send_event(input ccfs_pkg::opcode_e op, input ccfs_pkg::clock_state_t ld);
    ev_valid  <= 1'b1;
    ev_op     <= op;
    ld_hour   <= ld.hour;
    ld_minute <= ld.minute;
    ld_second <= ld.second;
    ld_day    <= ld.day;
    ld_month  <= ld.month;
    ld_year   <= ld.year;
    @(posedge clk);
    while (ev_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    ev_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin : stimulus
    ccfs_pkg::clock_state_t ones;
    ccfs_pkg::clock_state_t zeros;
    ccfs_pkg::clock_state_t leap_feb;
    ccfs_pkg::opcode_e      op;
    int                     pick;
    logic                   sender_idle_on;
    logic                   quiet;
    ones     = '{3'd0, 5'd31, 6'd63, 6'd63, 5'd31, 4'd15, 7'd127};
    zeros    = '0;
    leap_feb = '{3'd0, 5'd0, 6'd0, 6'd0, 5'd29, 4'd2, 7'd0};
    sender_idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Keys with no field selected still ask for a write-back.
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    // Out of range fields wrap back into range.
    send_event(ccfs_pkg::OP_LOAD, ones);
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_INC, random_load());
    // A load keeps the day mode; month zero counts as 31 days.
    send_event(ccfs_pkg::OP_LOAD, zeros);
    send_event(ccfs_pkg::OP_DEC, random_load());
    // Leap February wraps at 29 days.
    send_event(ccfs_pkg::OP_LOAD, leap_feb);
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    // Month and year wraps, then idle mode and the wrap back to none.
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_DEC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());
    send_event(ccfs_pkg::OP_INC, random_load());
    send_event(ccfs_pkg::OP_SET, random_load());

    // Random key sequences with occasional clock loads.
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      quiet = (i >= RANDOM_EVENTS - CALM_TAIL);
      if (i == RANDOM_EVENTS - CALM_TAIL) begin
        calm <= 1'b1;
      end
      if (i % 100 == 0) begin
        sender_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RANDOM_EVENTS / 2) begin
        // Let the block drain completely once.
        pause_sender(1);
        while (pending != 0) @(posedge clk);
      end else if (!quiet && sender_idle_on && $urandom_range(0, 4) == 0) begin
        pause_sender($urandom_range(1, 17));
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        op = ccfs_pkg::OP_LOAD;
      end else if (pick < 30) begin
        op = ccfs_pkg::OP_SET;
      end else if (pick < 65) begin
        op = ccfs_pkg::OP_INC;
      end else begin
        op = ccfs_pkg::OP_DEC;
      end
      send_event(op, random_load());
    end

    // Drain, then wait for any stray results to show up.
    pause_sender(1);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_calendar_clock_field_setter: done, clean");
    end else begin
      $display("tb_calendar_clock_field_setter: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
sv/ccfs_pkg.sv
sv/ccfs_field_calc.sv
sv/calendar_clock_field_setter.sv
tb/sv/ccfs_setting_checker.sv
tb/sv/tb_calendar_clock_field_setter.sv
